[design/playfair_encryptor_assert.svh]
// Assertion macros used by the checker of the Playfair encryptor.
`ifndef PLAYFAIR_ENCRYPTOR_ASSERT_SVH
`define PLAYFAIR_ENCRYPTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pfe_pkg.sv]
// Types, constants and helper functions of the Playfair encryptor.
`default_nettype none

package pfe_pkg;

    // Letter codes and square geometry.
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LETTER_X    = 5'd23;
    localparam logic [4:0] LETTER_Q    = 5'd16;
    localparam logic [4:0] ALPHABET    = 5'd26;
    localparam logic [4:0] LAST_LETTER = 5'd25;
    localparam logic [4:0] CELLS       = 5'd25;
    localparam int         ALPHA_N     = 26;
    localparam int         CELL_N      = 25;

    // Input item commands.
    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_MSG   = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic place_key;
        logic fill_clear;
        logic fill_step;
        logic pend_set;
        logic pair_msg;
        logic pair_end;
        logic cell_read;
        logic send_second;
        logic send_error;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic letter_ok;
        logic pending_valid;
        logic fill_done;
    } status_t;

    // Row of a cell index below 25.
    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p < 5'd5) r = 3'd0;
        else if (p < 5'd10) r = 3'd1;
        else if (p < 5'd15) r = 3'd2;
        else if (p < 5'd20) r = 3'd3;
        else r = 3'd4;
        return r;
    endfunction

    // Column of a cell index below 25.
    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] c;
        r = pos_row(p);
        c = p - ({2'b00, r} << 2) - {2'b00, r};
        return c[2:0];
    endfunction

    // Cell index from row and column.
    function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
        return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
    endfunction

    // Step to the next row or column, wrapping around the square.
    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

`default_nettype wire

[design/pfe_datapath.sv]
// Datapath of the Playfair encryptor: key square memories, digraph state and cipher lookup.
`default_nettype none

module pfe_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [4:0]       letter,
    input  pfe_pkg::ctl_t    ctl,
    output pfe_pkg::status_t status,
    output logic [4:0]       cipher_letter
);
    import pfe_pkg::*;

    // Key square: cell of each letter and letter of each cell.
    logic [4:0] letter_position_mem [ALPHA_N];
    logic [4:0] position_letter_mem [CELL_N];

    logic [25:0] placed_mask_reg, placed_mask_next;
    logic [4:0]  placed_count_reg, placed_count_next;
    logic [4:0]  pending_letter_reg, pending_letter_next;
    logic        pending_valid_reg, pending_valid_next;
    logic [4:0]  fill_cnt_reg, fill_cnt_next;

    logic [4:0]  pos_a_reg, pos_b_reg;
    logic [4:0]  cell_a_reg, cell_b_reg;

    logic [4:0]  place_letter;
    logic [31:0] mask_ext;
    logic        place_ok;
    logic [4:0]  addr_a, addr_b;
    logic        pos_read;
    logic [4:0]  pa, pb;
    logic [2:0]  ar, ac, br, bc;
    logic [2:0]  nar, nac, nbr, nbc;
    logic [4:0]  cell_a, cell_b;

    // Placement of a key letter or of the next letter of the fill walk.
    always_comb
    begin
        place_letter = ctl.fill_step ? fill_cnt_reg : letter;
        mask_ext     = {6'b0, placed_mask_reg};
        place_ok     = (ctl.place_key || ctl.fill_step) && (place_letter < ALPHABET)
                       && (place_letter != LETTER_J) && !mask_ext[place_letter]
                       && (placed_count_reg < CELLS);
    end

    // Digraph letters: a doubled letter pairs with X (a doubled X with Q); an end item pads with X.
    always_comb
    begin
        addr_a   = pending_letter_reg;
        pos_read = ctl.pair_msg || ctl.pair_end;
        if (ctl.pair_end)
        begin
            addr_b = LETTER_X;
        end
        else if (letter == pending_letter_reg)
        begin
            addr_b = (pending_letter_reg == LETTER_X) ? LETTER_Q : LETTER_X;
        end
        else
        begin
            addr_b = letter;
        end
    end

    // Cipher cells from the two square positions.
    always_comb
    begin
        pa  = (pos_a_reg < CELLS) ? pos_a_reg : 5'd0;
        pb  = (pos_b_reg < CELLS) ? pos_b_reg : 5'd0;
        ar  = pos_row(pa);
        ac  = pos_col(pa);
        br  = pos_row(pb);
        bc  = pos_col(pb);
        nar = ar;
        nac = ac;
        nbr = br;
        nbc = bc;
        if (ar == br)
        begin
            nac = wrap_inc(ac);
            nbc = wrap_inc(bc);
        end
        else if (ac == bc)
        begin
            nar = wrap_inc(ar);
            nbr = wrap_inc(br);
        end
        else
        begin
            nac = bc;
            nbc = ac;
        end
        cell_a = cell_index(nar, nac);
        cell_b = cell_index(nbr, nbc);
    end

    // Next values of the control registers.
    always_comb
    begin
        placed_mask_next    = placed_mask_reg;
        placed_count_next   = placed_count_reg;
        pending_letter_next = pending_letter_reg;
        pending_valid_next  = pending_valid_reg;
        fill_cnt_next       = fill_cnt_reg;
        if (place_ok)
        begin
            placed_mask_next  = placed_mask_reg | (26'd1 << place_letter);
            placed_count_next = placed_count_reg + 5'd1;
        end
        if (ctl.fill_clear)
        begin
            fill_cnt_next = 5'd0;
        end
        else if (ctl.fill_step)
        begin
            fill_cnt_next = fill_cnt_reg + 5'd1;
        end
        if (ctl.pend_set)
        begin
            pending_letter_next = letter;
            pending_valid_next  = 1'b1;
        end
        if (ctl.pair_end || (ctl.pair_msg && (letter != pending_letter_reg)))
        begin
            pending_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            placed_mask_reg    <= '0;
            placed_count_reg   <= '0;
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
            fill_cnt_reg       <= '0;
        end
        else
        begin
            placed_mask_reg    <= placed_mask_next;
            placed_count_reg   <= placed_count_next;
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
            fill_cnt_reg       <= fill_cnt_next;
        end
    end

    // Square memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (place_ok)
        begin
            letter_position_mem[place_letter]     <= placed_count_reg;
            position_letter_mem[placed_count_reg] <= place_letter;
        end
        if (pos_read)
        begin
            pos_a_reg <= letter_position_mem[addr_a];
            pos_b_reg <= letter_position_mem[addr_b];
        end
        if (ctl.cell_read)
        begin
            cell_a_reg <= position_letter_mem[cell_a];
            cell_b_reg <= position_letter_mem[cell_b];
        end
    end

    // Status and result letter.
    assign status.letter_ok     = (letter < ALPHABET) && (letter != LETTER_J);
    assign status.pending_valid = pending_valid_reg;
    assign status.fill_done     = (fill_cnt_reg == LAST_LETTER);

    assign cipher_letter = ctl.send_error  ? 5'd0 :
                           ctl.send_second ? cell_b_reg : cell_a_reg;

endmodule

`default_nettype wire

[design/pfe_ctrl.sv]
// Controller of the Playfair encryptor: command decode, fill walk and result sequencing.
`default_nettype none

module pfe_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [1:0]       command,
    output logic             result_valid,
    input  logic             result_stall,
    output logic             last,
    output logic             error,
    input  pfe_pkg::status_t status,
    output pfe_pkg::ctl_t    ctl
);
    import pfe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_CELL,
        ST_SEND0,
        ST_SEND1,
        ST_ERR
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, last_reg, error_reg;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (cmd_t'(command))
                        CMD_KEY:
                        begin
                            ctl.place_key = 1'b1;
                        end
                        CMD_CLOSE:
                        begin
                            ctl.fill_clear = 1'b1;
                            state_next     = ST_FILL;
                        end
                        CMD_MSG:
                        begin
                            if (!status.letter_ok)
                            begin
                                state_next = ST_ERR;
                            end
                            else if (!status.pending_valid)
                            begin
                                ctl.pend_set = 1'b1;
                            end
                            else
                            begin
                                ctl.pair_msg = 1'b1;
                                state_next   = ST_CELL;
                            end
                        end
                        CMD_END:
                        begin
                            if (status.pending_valid)
                            begin
                                ctl.pair_end = 1'b1;
                                state_next   = ST_CELL;
                            end
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                ctl.fill_step = 1'b1;
                if (status.fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CELL:
            begin
                ctl.cell_read = 1'b1;
                state_next    = ST_SEND0;
            end
            ST_SEND0:
            begin
                if (!result_stall)
                begin
                    state_next = ST_SEND1;
                end
            end
            ST_SEND1:
            begin
                ctl.send_second = 1'b1;
                if (!result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                ctl.send_error = 1'b1;
                if (!result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered result flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            last_reg         <= 1'b0;
            error_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_next == ST_SEND0) || (state_next == ST_SEND1)
                                || (state_next == ST_ERR);
            last_reg         <= (state_next == ST_SEND1) || (state_next == ST_ERR);
            error_reg        <= (state_next == ST_ERR);
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign last         = last_reg;
    assign error        = error_reg;

endmodule

`default_nettype wire

[design/playfair_encryptor.sv]
// A key letter or first message letter ends on acceptance; close key runs the fill walk. A
// digraph's first beat follows the registered square positions and cells, the second once
// the first is taken. An error beat appears in the cycle after its item. One item is worked
// on at a time; a pair is paced by the two registered square reads and two result beats.
// Reset is asynchronous and active low; it clears the controller, placed mask, counts and
// pending letter. The square memories are not cleared.
`default_nettype none

module playfair_encryptor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] command,
    input  logic [4:0] letter,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [4:0] cipher_letter,
    output logic       last,
    output logic       error
);
    import pfe_pkg::*;

    ctl_t    ctl;
    status_t status;

    // Sequencing of items and result beats.
    pfe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .last         (last),
        .error        (error),
        .status       (status),
        .ctl          (ctl)
    );

    // Key square and cipher lookup.
    pfe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .letter        (letter),
        .ctl           (ctl),
        .status        (status),
        .cipher_letter (cipher_letter)
    );

endmodule

`default_nettype wire

[design/pfe_checker.sv]
// Port-level assertions of the Playfair encryptor and their binding to the top level.
`default_nettype none

`include "playfair_encryptor_assert.svh"

module pfe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic [1:0] command,
    input wire logic [4:0] letter,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [4:0] cipher_letter,
    input wire logic       last,
    input wire logic       error
);
    import pfe_pkg::*;

    // A stalled beat holds its payload.
    `PFE_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(cipher_letter) && $stable(last) && $stable(error), "stalled result beat changed")

    // The first letter of a digraph is always followed at once by the second.
    `PFE_ASSERT_NEXT(a_pair, clk, rst_n, result_valid && !result_stall && !last, result_valid && last && !error, "second digraph beat missing")

    // A message letter J gives an error beat in the next cycle.
    `PFE_ASSERT_NEXT(a_bad_letter, clk, rst_n, item_valid && !item_stall && (command == CMD_MSG) && (letter == LETTER_J), result_valid && error, "error beat missing for letter J")

    // No new item is taken while a result is being delivered, and an error beat is last with a zero letter.
    `PFE_ASSERT_SAME(a_one_item, clk, rst_n, result_valid, item_stall && (!error || (last && (cipher_letter == 5'd0))), "item taken during result or bad error beat")

endmodule

bind playfair_encryptor pfe_checker u_pfe_checker (.*);

`default_nettype wire

[tb/playfair_encryptor_test.sv]
// Self-checking testbench of the Playfair encryptor: directed rows, then random item traffic.
`timescale 1ns / 100ps

module playfair_encryptor_test;
    import pfe_pkg::*;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [4:0] cipher;
        logic       last;
        logic       error;
    } beat_t;

    // One row of the directed table; typed rows carry their own beat count.
    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] letter;
        logic       typed;
        logic [1:0] beats;
    } stim_row_t;

    localparam int    SIDE         = 5;
    localparam int    RANDOM_ITEMS = 450;
    localparam int    HOLD_AT      = 100;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    PAUSE_AT     = 250;
    localparam int    STEADY_FROM  = 300;
    localparam int    STEADY_TO    = 380;
    localparam int    DRAIN_CYCLES = 40;
    localparam int    CYCLE_LIMIT  = 200000;
    localparam beat_t ERROR_BEAT   = '{cipher: 5'd0, last: 1'b1, error: 1'b1};

    // Key PLAYZ gives the square PLAYZ / BCDEF / GHIKM / NOQRS / TUVWX.
    localparam stim_row_t DIRECTED_ROWS [24] = '{
        '{CMD_KEY,   5'd15, 1'b1, 2'd0},  // P
        '{CMD_KEY,   5'd11, 1'b1, 2'd0},  // L
        '{CMD_KEY,   5'd0,  1'b1, 2'd0},  // A
        '{CMD_KEY,   5'd24, 1'b1, 2'd0},  // Y
        '{CMD_KEY,   5'd0,  1'b1, 2'd0},  // repeated A is dropped
        '{CMD_KEY,   5'd9,  1'b1, 2'd0},  // J is dropped
        '{CMD_KEY,   5'd31, 1'b1, 2'd0},  // out of the alphabet
        '{CMD_KEY,   5'd25, 1'b1, 2'd0},  // Z
        '{CMD_KEY,   5'd26, 1'b1, 2'd0},  // first code past Z
        '{CMD_MSG,   5'd9,  1'b1, 2'd1},  // message J is an error
        '{CMD_MSG,   5'd31, 1'b1, 2'd1},  // message past Z is an error
        '{CMD_END,   5'd0,  1'b1, 2'd0},  // nothing pending
        '{CMD_CLOSE, 5'd0,  1'b1, 2'd0},
        '{CMD_CLOSE, 5'd31, 1'b1, 2'd0},  // square already full
        '{CMD_KEY,   5'd1,  1'b1, 2'd0},  // square full
        '{CMD_MSG,   5'd0,  1'b1, 2'd0},  // A opens a pair
        '{CMD_MSG,   5'd0,  1'b0, 2'd0},  // doubled A pairs with X
        '{CMD_MSG,   5'd30, 1'b1, 2'd1},  // error keeps the pending A
        '{CMD_MSG,   5'd25, 1'b0, 2'd0},  // A,Z in one row, wraps
        '{CMD_MSG,   5'd23, 1'b1, 2'd0},  // X opens a pair
        '{CMD_MSG,   5'd23, 1'b0, 2'd0},  // doubled X pairs with Q
        '{CMD_END,   5'd0,  1'b0, 2'd0},  // pending X pads to X,X
        '{CMD_MSG,   5'd15, 1'b1, 2'd0},  // P opens a pair
        '{CMD_MSG,   5'd1,  1'b0, 2'd0}   // P,B in one column
    };

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic [1:0] command      = CMD_KEY;
    logic [4:0] letter       = 5'd0;
    logic       result_stall = 1'b0;
    logic       item_stall;
    logic       result_valid;
    logic [4:0] cipher_letter;
    logic       last;
    logic       error;

    // Shadow of the key square and the open digraph.
    logic [4:0]  cell_of [ALPHA_N];
    logic [4:0]  letter_in_cell [CELL_N];
    logic [25:0] placed_letters = '0;
    int          filled_cells   = 0;
    logic [4:0]  held_letter    = 5'd0;
    logic        held_valid     = 1'b0;

    beat_t cipher_due [$];
    int    failures      = 0;
    int    cycle_count   = 0;
    int    hold_requests = 0;
    int    holds_served  = 0;
    int    hold_left     = 0;
    bit    steady        = 1'b0;

    playfair_encryptor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .letter       (letter),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cipher_letter(cipher_letter),
        .last         (last),
        .error        (error)
    );

    always #10 clk = ~clk;

    // Put a key letter into the next free cell if it is new and usable.
    function automatic void square_add(input logic [4:0] l);
        if (l <= LAST_LETTER && l != LETTER_J) begin
            if (!placed_letters[l] && filled_cells < CELL_N) begin
                cell_of[l] = 5'(filled_cells);
                letter_in_cell[filled_cells] = l;
                placed_letters[l] = 1'b1;
                filled_cells++;
            end
        end
    endfunction

    // Encrypt one digraph by the row, column and rectangle rules.
    function automatic void encode_pair(input logic [4:0] a, input logic [4:0] b,
                                        output beat_t first, output beat_t second);
        int ar, ac, br, bc, t;
        ar = int'(cell_of[a]) / SIDE;
        ac = int'(cell_of[a]) % SIDE;
        br = int'(cell_of[b]) / SIDE;
        bc = int'(cell_of[b]) % SIDE;
        if (ar == br) begin
            ac = (ac + 1) % SIDE;
            bc = (bc + 1) % SIDE;
        end else if (ac == bc) begin
            ar = (ar + 1) % SIDE;
            br = (br + 1) % SIDE;
        end else begin
            t  = ac;
            ac = bc;
            bc = t;
        end
        first  = '{cipher: letter_in_cell[ar * SIDE + ac], last: 1'b0, error: 1'b0};
        second = '{cipher: letter_in_cell[br * SIDE + bc], last: 1'b1, error: 1'b0};
    endfunction

    // Advance the shadow state by one item and return the beats it causes.
    function automatic int predict_cipher(input cmd_t cmd, input logic [4:0] l,
                                          output beat_t b0, output beat_t b1);
        int n;
        n  = 0;
        b0 = '0;
        b1 = '0;
        case (cmd)
            CMD_KEY: square_add(l);
            CMD_CLOSE: begin
                for (int i = 0; i < ALPHA_N; i++) square_add(5'(i));
            end
            CMD_MSG: begin
                if (l > LAST_LETTER || l == LETTER_J) begin
                    b0 = ERROR_BEAT;
                    n  = 1;
                end else if (!held_valid) begin
                    held_letter = l;
                    held_valid  = 1'b1;
                end else if (held_letter == l) begin
                    // The repeated letter stays pending and opens the next pair.
                    encode_pair(l, (l == LETTER_X) ? LETTER_Q : LETTER_X, b0, b1);
                    n = 2;
                end else begin
                    held_valid = 1'b0;
                    encode_pair(held_letter, l, b0, b1);
                    n = 2;
                end
            end
            default: begin
                if (held_valid) begin
                    held_valid = 1'b0;
                    encode_pair(held_letter, LETTER_X, b0, b1);
                    n = 2;
                end
            end
        endcase
        return n;
    endfunction

    // A message letter that is neither J nor past Z.
    function automatic logic [4:0] plain_letter();
        logic [4:0] l;
        l = 5'($urandom_range(24));
        if (l >= LETTER_J) l = l + 5'd1;
        return l;
    endfunction

    // Present one item, wait until it is accepted, and queue what it should produce.
    task automatic offer(input cmd_t cmd, input logic [4:0] l, input bit typed,
                         input int typed_beats);
        beat_t b0, b1;
        int    n;
        item_valid <= 1'b1;
        command    <= cmd;
        letter     <= l;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        n = predict_cipher(cmd, l, b0, b1);
        if (typed) begin
            n  = typed_beats;
            b0 = ERROR_BEAT;
        end
        if (n > 0) cipher_due = {cipher_due, b0};
        if (n > 1) cipher_due = {cipher_due, b1};
    endtask

    // Drop valid for a random gap, or always when asked; steady traffic gets no random gap.
    task automatic idle_gap(input bit at_least_one);
        if (at_least_one || (!steady && $urandom_range(99) < 32)) begin
            item_valid <= 1'b0;
            @(posedge clk);
            while (!steady && $urandom_range(99) < 32) @(posedge clk);
        end
    endtask

    // Result side: check each accepted beat, then choose the next stall.
    always @(posedge clk) begin : result_side
        beat_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (cipher_due.size() == 0) begin
                $error("unexpected beat: cipher_letter %0d last %0d error %0d",
                       cipher_letter, last, error);
                failures++;
            end else begin
                want = cipher_due.pop_front();
                if (cipher_letter !== want.cipher) begin
                    $error("cipher_letter: expected %0d, actual %0d", want.cipher, cipher_letter);
                    failures++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    failures++;
                end
                if (error !== want.error) begin
                    $error("error: expected %0d, actual %0d", want.error, error);
                    failures++;
                end
            end
        end
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_stall <= 1'b1;
        end else if (steady) begin
            result_stall <= 1'b0;
        end else begin
            result_stall <= ($urandom_range(99) < 32);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then random traffic on the closed square.
    initial begin : item_side
        int         scored;
        int         roll;
        cmd_t       cmd;
        logic [4:0] l;
        bit         paused;
        scored = 0;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i]) begin
            offer(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].letter, DIRECTED_ROWS[i].typed,
                  int'(DIRECTED_ROWS[i].beats));
            idle_gap(1'b0);
        end

        while (scored < RANDOM_ITEMS) begin
            // Long receiver hold-off while items keep coming.
            if (scored == HOLD_AT && hold_requests == 0) hold_requests++;
            // One full drain before going on.
            if (scored == PAUSE_AT && !paused) begin
                paused = 1'b1;
                idle_gap(1'b1);
                while (cipher_due.size() != 0) @(posedge clk);
            end
            steady = (scored >= STEADY_FROM && scored < STEADY_TO);

            roll = $urandom_range(99);
            l    = 5'($urandom_range(31));
            if (roll < 58) begin
                cmd = CMD_MSG;
                if (held_valid && $urandom_range(3) == 0) l = held_letter;
                else if ($urandom_range(9) == 0) l = LETTER_X;
                else l = plain_letter();
            end else if (roll < 72) begin
                cmd = CMD_END;
            end else if (roll < 86) begin
                cmd = CMD_MSG;
                l   = ($urandom_range(1) == 0) ? LETTER_J : 5'($urandom_range(31, 26));
            end else if (roll < 95) begin
                cmd = CMD_KEY;
            end else begin
                cmd = CMD_CLOSE;
            end
            offer(cmd, l, 1'b0, 0);
            scored++;
            idle_gap(1'b0);
        end
        steady = 1'b0;

        // Drain and let the block settle before the verdict.
        idle_gap(1'b1);
        while (cipher_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
